// ===== hw/rtl/tqd_pkg.sv =====
// Package for the task queue dispatcher: request and response structs,
// command codes, queue and task status codes, FSM states and counter helpers.
// No dependencies.
package tqd_pkg;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned TaskSlots  = 64;
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  localparam int unsigned TaskW      = $clog2(TaskSlots);
  localparam int unsigned CntW       = 7;
  localparam int unsigned PaddrW     = 2;

  localparam logic [3:0] CMD_INIT     = 4'd0;
  localparam logic [3:0] CMD_ENQUEUE  = 4'd1;
  localparam logic [3:0] CMD_DEQ_ONE  = 4'd2;
  localparam logic [3:0] CMD_DEQ_MANY = 4'd3;
  localparam logic [3:0] CMD_START    = 4'd4;
  localparam logic [3:0] CMD_STOP     = 4'd5;
  localparam logic [3:0] CMD_RESET    = 4'd6;
  localparam logic [3:0] CMD_CLAIM    = 4'd7;
  localparam logic [3:0] CMD_RUN_ONE  = 4'd8;
  localparam logic [3:0] CMD_FINISH   = 4'd9;
  localparam logic [3:0] CMD_QUERY    = 4'd10;

  localparam logic [PaddrW-1:0] REG_CAPACITY = 2'd0;

  typedef enum logic [2:0] {
    QS_INIT     = 3'd0,
    QS_READY    = 3'd1,
    QS_STOPPING = 3'd2,
    QS_STOPPED  = 3'd3,
    QS_FINISHED = 3'd4
  } qstate_e;

  typedef enum logic [2:0] {
    TS_INIT     = 3'd0,
    TS_READY    = 3'd1,
    TS_RUNNING  = 3'd2,
    TS_FINISHED = 3'd3,
    TS_UNUSED   = 3'd4
  } tstatus_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT,
    ST_WALK_RD,
    ST_WALK_EMIT,
    ST_RST_RD,
    ST_RST_WR
  } fsm_e;

  typedef struct packed {
    logic [3:0]       cmd;
    logic [TaskW-1:0] task_id;
    logic [CntW-1:0]  count;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [TaskW-1:0] out_task;
    logic [2:0]       queue_state;
    logic [CntW-1:0]  total_tasks;
    logic [CntW-1:0]  ready_tasks;
    logic [CntW-1:0]  running_tasks;
    logic [CntW-1:0]  finished_tasks;
    logic             last;
  } rsp_t;

  function automatic logic [CntW-1:0] inc_sat(input logic [CntW-1:0] v,
                                              input logic [CntW-1:0] n);
    logic [CntW:0] s;
    s = {1'b0, v} + {1'b0, n};
    return s[CntW] ? {CntW{1'b1}} : s[CntW-1:0];
  endfunction

  function automatic logic [CntW-1:0] dec_sat(input logic [CntW-1:0] v,
                                              input logic [CntW-1:0] n);
    return (v > n) ? v - n : '0;
  endfunction

endpackage

// ===== hw/rtl/task_queue_dispatcher_core.sv =====
// Task queue dispatcher top level: command FSM, task list memory, task status
// memory with per-entry valid bits, counters and APB capacity register.
// Depends on tqd_pkg.
//
// channel   dir  handshake              payload
// request   in   in_valid_i/in_stall_o  in_req_i (cmd, task_id, count)
// response  out  out_valid_o/out_stall_i out_rsp_o (ok .. last)
// config    in   APB psel/penable       queue_capacity at address 0
//
// A single-result command steps through accept and memory read, execute and
// the response register load, which waits out output stall. Dequeue many and
// claim follow execute with a list read and an emit per task; queue reset puts
// a list read and status write per list entry before the load. One command is
// in flight at a time; the next one is accepted while its last response still
// sits in the output register. Reset marks every task status entry unused
// through valid bits at once.
module task_queue_dispatcher_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  tqd_pkg::req_t              in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output tqd_pkg::rsp_t              out_rsp_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tqd_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import tqd_pkg::*;

  // memories
  logic [TaskW-1:0] list_mem [QueueDepth];
  logic [2:0]       stat_mem [TaskSlots];
  logic [TaskSlots-1:0] stat_vld_q;

  logic [CntW-1:0] cap_q;
  fsm_e            fsm_q, fsm_d;
  qstate_e         qs_q, qs_d;
  req_t            req_q, req_d;
  logic [CntW-1:0] len_q, len_d, ri_q, ri_d;
  logic [CntW-1:0] tot_q, tot_d, rdy_q, rdy_d, run_q, run_d, fin_q, fin_d;
  logic [CntW-1:0] ptr_q, ptr_d, rem_q, rem_d;
  logic            ok_q, ok_d;
  logic [TaskW-1:0] task_q, task_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_q, out_d;

  logic             list_we;
  logic [IdxW-1:0]  list_waddr, list_raddr;
  logic [TaskW-1:0] list_wdata, list_rdata_q;
  logic             stat_we;
  logic [TaskW-1:0] stat_waddr, stat_raddr;
  logic [2:0]       stat_wdata, stat_rdata_q;
  logic             stat_rvld_q;
  logic [2:0]       stat_rd;

  logic            accept, out_free, emit;
  logic            emit_ok, emit_last;
  logic [TaskW-1:0] emit_task;
  logic [CntW-1:0] cap_eff, avail, take_n, fin_new, run_new;

  // config
  assign pready = 1'b1;
  assign prdata = {{(32-CntW){1'b0}}, cap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CntW'(64);
    end else if (psel && penable && pwrite && paddr == REG_CAPACITY) begin
      cap_q <= pwdata[CntW-1:0];
    end
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (list_we) list_mem[list_waddr] <= list_wdata;
    list_rdata_q <= list_mem[list_raddr];
    if (stat_we) stat_mem[stat_waddr] <= stat_wdata;
    stat_rdata_q <= stat_mem[stat_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_vld_q  <= '0;
      stat_rvld_q <= 1'b0;
    end else begin
      if (stat_we) stat_vld_q[stat_waddr] <= 1'b1;
      stat_rvld_q <= stat_vld_q[stat_raddr];
    end
  end

  assign stat_rd = stat_rvld_q ? stat_rdata_q : TS_UNUSED;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (fsm_q != ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  assign cap_eff = (cap_q < CntW'(QueueDepth)) ? cap_q : CntW'(QueueDepth);
  assign avail   = (len_q > ri_q) ? len_q - ri_q : '0;
  assign take_n  = (req_q.count < avail) ? req_q.count : avail;
  assign run_new = dec_sat(run_q, CntW'(1));
  assign fin_new = inc_sat(fin_q, CntW'(1));

  always_comb begin
    fsm_d = fsm_q;
    qs_d = qs_q;
    req_d = req_q;
    len_d = len_q;
    ri_d = ri_q;
    tot_d = tot_q;
    rdy_d = rdy_q;
    run_d = run_q;
    fin_d = fin_q;
    ptr_d = ptr_q;
    rem_d = rem_q;
    ok_d = ok_q;
    task_d = task_q;
    list_we = 1'b0;
    list_waddr = len_q[IdxW-1:0];
    list_wdata = req_q.task_id;
    list_raddr = ri_q[IdxW-1:0];
    stat_we = 1'b0;
    stat_waddr = req_q.task_id;
    stat_wdata = TS_INIT;
    stat_raddr = in_req_i.task_id;
    emit = 1'b0;
    emit_ok = ok_q;
    emit_task = task_q;
    emit_last = 1'b1;

    case (fsm_q)
      ST_IDLE: begin
        if (accept) begin
          req_d = in_req_i;
          fsm_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ok_d = 1'b0;
        task_d = '0;
        fsm_d = ST_EMIT;
        case (req_q.cmd)
          CMD_INIT: begin
            stat_we = 1'b1;
            stat_wdata = TS_INIT;
            ok_d = 1'b1;
          end
          CMD_ENQUEUE: begin
            if (stat_rd == TS_INIT && len_q < cap_eff) begin
              stat_we = 1'b1;
              stat_wdata = TS_READY;
              list_we = 1'b1;
              tot_d = inc_sat(tot_q, CntW'(1));
              rdy_d = inc_sat(rdy_q, CntW'(1));
              len_d = len_q + CntW'(1);
              if (qs_q == QS_FINISHED) qs_d = QS_READY;
              ok_d = 1'b1;
            end
          end
          CMD_DEQ_ONE: begin
            if (qs_q == QS_READY && ri_q < len_q) begin
              task_d = list_rdata_q;
              ri_d = ri_q + CntW'(1);
              ok_d = 1'b1;
            end
          end
          CMD_DEQ_MANY, CMD_CLAIM: begin
            if (qs_q == QS_READY && take_n != '0) begin
              ptr_d = ri_q;
              rem_d = take_n;
              ri_d = ri_q + take_n;
              if (req_q.cmd == CMD_CLAIM) begin
                rdy_d = dec_sat(rdy_q, take_n);
                run_d = inc_sat(run_q, take_n);
              end
              fsm_d = ST_WALK_RD;
            end
          end
          CMD_START: begin
            if (qs_q == QS_INIT || qs_q == QS_STOPPED) begin
              qs_d = QS_READY;
              ok_d = 1'b1;
            end
          end
          CMD_STOP: begin
            if (qs_q == QS_READY) begin
              qs_d = (run_q == '0) ? QS_STOPPED : QS_STOPPING;
              ok_d = 1'b1;
            end
          end
          CMD_RESET: begin
            if (qs_q == QS_FINISHED || qs_q == QS_STOPPED) begin
              qs_d = QS_INIT;
              tot_d = len_q;
              rdy_d = len_q;
              run_d = '0;
              fin_d = '0;
              ri_d = '0;
              ptr_d = '0;
              ok_d = 1'b1;
              if (len_q != '0) fsm_d = ST_RST_RD;
            end
          end
          CMD_RUN_ONE: begin
            if (stat_rd == TS_READY && qs_q != QS_STOPPING && qs_q != QS_STOPPED) begin
              rdy_d = dec_sat(rdy_q, CntW'(1));
              run_d = inc_sat(run_q, CntW'(1));
              stat_we = 1'b1;
              stat_wdata = TS_RUNNING;
              ok_d = 1'b1;
            end
          end
          CMD_FINISH: begin
            if (stat_rd == TS_RUNNING) begin
              stat_we = 1'b1;
              stat_wdata = TS_FINISHED;
              run_d = run_new;
              fin_d = fin_new;
              if (qs_q == QS_STOPPING && run_new == '0) qs_d = QS_STOPPED;
              if (tot_q == fin_new) qs_d = QS_FINISHED;
              ok_d = 1'b1;
            end
          end
          CMD_QUERY: ok_d = 1'b1;
          default: ok_d = 1'b0;
        endcase
      end
      ST_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          fsm_d = ST_IDLE;
        end
      end
      ST_WALK_RD: begin
        list_raddr = ptr_q[IdxW-1:0];
        fsm_d = ST_WALK_EMIT;
      end
      ST_WALK_EMIT: begin
        // hold the read address so the entry stays put while stalled
        list_raddr = ptr_q[IdxW-1:0];
        emit_ok = 1'b1;
        emit_task = list_rdata_q;
        emit_last = (rem_q == CntW'(1));
        stat_waddr = list_rdata_q;
        stat_wdata = TS_RUNNING;
        if (out_free) begin
          emit = 1'b1;
          stat_we = (req_q.cmd == CMD_CLAIM);
          ptr_d = ptr_q + CntW'(1);
          rem_d = rem_q - CntW'(1);
          fsm_d = emit_last ? ST_IDLE : ST_WALK_RD;
        end
      end
      ST_RST_RD: begin
        list_raddr = ptr_q[IdxW-1:0];
        fsm_d = ST_RST_WR;
      end
      ST_RST_WR: begin
        // mark each listed task ready again
        stat_we = 1'b1;
        stat_waddr = list_rdata_q;
        stat_wdata = TS_READY;
        ptr_d = ptr_q + CntW'(1);
        fsm_d = (ptr_d == len_q) ? ST_EMIT : ST_RST_RD;
      end
      default: fsm_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d.ok = emit_ok;
      out_d.out_task = emit_task;
      out_d.queue_state = qs_q;
      out_d.total_tasks = tot_q;
      out_d.ready_tasks = rdy_q;
      out_d.running_tasks = run_q;
      out_d.finished_tasks = fin_q;
      out_d.last = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= ST_IDLE;
      qs_q <= QS_INIT;
      len_q <= '0;
      ri_q <= '0;
      tot_q <= '0;
      rdy_q <= '0;
      run_q <= '0;
      fin_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q <= fsm_d;
      qs_q <= qs_d;
      len_q <= len_d;
      ri_q <= ri_d;
      tot_q <= tot_d;
      rdy_q <= rdy_d;
      run_q <= run_d;
      fin_q <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    ptr_q <= ptr_d;
    rem_q <= rem_d;
    ok_q <= ok_d;
    task_q <= task_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o = out_q;

endmodule
